// ===== src/acm_pkg.sv =====
// Shared types and constants for the Aho-Corasick match step block.
// No dependencies; imported by the top level, the controller and the datapath.
`default_nettype none
package acm_pkg;

    localparam int STATE_W  = 8;
    localparam int SYM_W    = 8;
    localparam int TGT_W    = 9;
    localparam int PAT_W    = 16;
    localparam int IDX_W    = 4;
    localparam int MAX_FAIL = 5;
    localparam int FCNT_W   = $clog2(MAX_FAIL + 1);
    localparam int GOTO_AW  = STATE_W + SYM_W;

    // Patterns that count in the bitmap (all sixteen at this size).
    localparam logic [PAT_W-1:0] PAT_MASK   = 16'hFFFF;
    localparam logic [TGT_W-1:0] GOTO_UNDEF = 9'h1FF;

    // Item opcodes.
    typedef enum logic [1:0] {
        CMD_SEARCH = 2'd0,
        CMD_GOTO   = 2'd1,
        CMD_FAIL   = 2'd2,
        CMD_OUT    = 2'd3
    } acm_op_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GOTO_CHK,
        ST_FAIL_CHK,
        ST_OUT_CHK,
        ST_WR_DONE
    } acm_state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic start_search;
        logic write_entry;
        logic take_goto;
        logic fail_rd;
        logic take_dead;
        logic next_goto;
        logic load_match;
        logic load_zero;
    } acm_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic goto_def;
        logic fail_left;
        logic out_free;
    } acm_stat_t;

endpackage
`default_nettype wire

// ===== src/aho_corasick_match_step.sv =====
// Top level of the Aho-Corasick match step: controller plus datapath.
// Depends on acm_pkg, acm_ctrl and acm_dp.
//
//   channel | direction | ports
//   --------+-----------+-------------------------------------------------
//   s_      | in        | s_valid, s_ready, cmd, restart, symbol, entry_*
//   m_      | out       | m_valid, m_ready, match_hit, match_index, dead_end
//
// A search word starts with a registered goto memory read, then follows k
// failure links, where k (0 to 5) is their number; each link costs one
// failure memory read and one goto memory read, both registered. A registered
// output bitmap read feeds the result. One word is in flight at a time.
// Reset returns the automaton to the root; the tables are not cleared.
// A stalled result waits in the output register while the next word is taken.
`default_nettype none
module aho_corasick_match_step (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_cmd,
    input  wire logic               s_restart,
    input  wire logic [7:0]         s_symbol,
    input  wire logic [7:0]         s_entry_state,
    input  wire logic signed [8:0]  s_entry_target,
    input  wire logic [15:0]        s_entry_patterns,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_match_hit,
    output logic [3:0]              m_match_index,
    output logic                    m_dead_end
);
    import acm_pkg::*;

    acm_cmd_t  cmd;
    acm_stat_t stat;

    acm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_cmd),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    acm_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .s_cmd            (s_cmd),
        .s_restart        (s_restart),
        .s_symbol         (s_symbol),
        .s_entry_state    (s_entry_state),
        .s_entry_target   (s_entry_target),
        .s_entry_patterns (s_entry_patterns),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_match_hit      (m_match_hit),
        .m_match_index    (m_match_index),
        .m_dead_end       (m_dead_end)
    );

endmodule
`default_nettype wire

// ===== src/acm_ctrl.sv =====
// Controller state machine for the Aho-Corasick match step.
// Depends on acm_pkg for the state, opcode, command and status types.
`default_nettype none
module acm_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic [1:0]         s_cmd,
    output logic                    s_ready,
    input  wire acm_pkg::acm_stat_t stat,
    output acm_pkg::acm_cmd_t       cmd
);
    import acm_pkg::*;

    acm_state_t state_reg;
    acm_state_t state_next;
    acm_op_t    op;

    assign op      = acm_op_t'(s_cmd);
    assign s_ready = (state_reg == ST_IDLE);

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (op == CMD_SEARCH) ? ST_GOTO_CHK : ST_WR_DONE;
                end
            end
            ST_GOTO_CHK: begin
                if (!stat.goto_def && stat.fail_left) begin
                    state_next = ST_FAIL_CHK;
                end else begin
                    state_next = ST_OUT_CHK;
                end
            end
            ST_FAIL_CHK: state_next = ST_GOTO_CHK;
            ST_OUT_CHK: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_WR_DONE: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (op == CMD_SEARCH) begin
                        cmd.start_search = 1'b1;
                    end else begin
                        cmd.write_entry = 1'b1;
                    end
                end
            end
            ST_GOTO_CHK: begin
                if (stat.goto_def) begin
                    cmd.take_goto = 1'b1;
                end else if (stat.fail_left) begin
                    cmd.fail_rd = 1'b1;
                end else begin
                    cmd.take_dead = 1'b1;
                end
            end
            ST_FAIL_CHK: cmd.next_goto = 1'b1;
            ST_OUT_CHK:  cmd.load_match = stat.out_free;
            ST_WR_DONE:  cmd.load_zero = stat.out_free;
            default: cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== src/acm_dp.sv =====
// Datapath for the Aho-Corasick match step: goto, failure and output
// memories, the walk registers and the result register. Depends on acm_pkg.
`default_nettype none
module acm_dp (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire acm_pkg::acm_cmd_t  cmd,
    output acm_pkg::acm_stat_t      stat,
    input  wire logic [1:0]         s_cmd,
    input  wire logic               s_restart,
    input  wire logic [7:0]         s_symbol,
    input  wire logic [7:0]         s_entry_state,
    input  wire logic signed [8:0]  s_entry_target,
    input  wire logic [15:0]        s_entry_patterns,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_match_hit,
    output logic [3:0]              m_match_index,
    output logic                    m_dead_end
);
    import acm_pkg::*;

    // Table storage; entries hold garbage until written.
    logic [TGT_W-1:0]   goto_mem [2**GOTO_AW];
    logic [STATE_W-1:0] fail_mem [2**STATE_W];
    logic [PAT_W-1:0]   out_mem  [2**STATE_W];

    logic [TGT_W-1:0]   goto_q;
    logic [STATE_W-1:0] fail_q;
    logic [PAT_W-1:0]   out_q;

    logic [STATE_W-1:0] cur_reg, cur_next;
    logic [STATE_W-1:0] st_reg;
    logic [SYM_W-1:0]   sym_reg;
    logic [FCNT_W-1:0]  fcnt_reg;
    logic               dead_reg;

    logic               m_valid_reg, m_valid_next;
    logic               found_reg;
    logic [IDX_W-1:0]   index_reg;
    logic               dead_out_reg;

    acm_op_t            op;
    logic [STATE_W-1:0] st0;
    logic [GOTO_AW-1:0] goto_raddr;
    logic [STATE_W-1:0] out_raddr;
    logic               goto_re;
    logic               out_re;
    logic [PAT_W-1:0]   bits;
    logic               bits_any;
    logic [IDX_W-1:0]   bits_low;

    assign op  = acm_op_t'(s_cmd);
    assign st0 = s_restart ? '0 : cur_reg;

    // Goto read comes from the item at accept or from a failure link.
    assign goto_re    = cmd.start_search | cmd.next_goto;
    assign goto_raddr = cmd.start_search ? {st0, s_symbol} : {fail_q, sym_reg};

    // Output bitmap read follows the goto hit, or the root on a dead end.
    assign out_re    = cmd.take_goto | cmd.take_dead;
    assign out_raddr = cmd.take_goto ? goto_q[STATE_W-1:0] : '0;

    // Goto memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.write_entry && op == CMD_GOTO) begin
            goto_mem[{s_entry_state, s_symbol}] <=
                s_entry_target[TGT_W-1] ? GOTO_UNDEF : s_entry_target;
        end
        if (goto_re) begin
            goto_q <= goto_mem[goto_raddr];
        end
    end

    // Failure memory; negative targets are dropped.
    always_ff @(posedge aclk) begin
        if (cmd.write_entry && op == CMD_FAIL && !s_entry_target[TGT_W-1]) begin
            fail_mem[s_entry_state] <= s_entry_target[STATE_W-1:0];
        end
        if (cmd.fail_rd) begin
            fail_q <= fail_mem[st_reg];
        end
    end

    // Output bitmap memory.
    always_ff @(posedge aclk) begin
        if (cmd.write_entry && op == CMD_OUT) begin
            out_mem[s_entry_state] <= s_entry_patterns;
        end
        if (out_re) begin
            out_q <= out_mem[out_raddr];
        end
    end

    // Walk registers: state under test, symbol, failure count and dead-end flag.
    always_ff @(posedge aclk) begin
        if (cmd.start_search) begin
            st_reg   <= st0;
            sym_reg  <= s_symbol;
            fcnt_reg <= '0;
        end else begin
            if (cmd.next_goto) begin
                st_reg <= fail_q;
            end
            if (cmd.fail_rd) begin
                fcnt_reg <= fcnt_reg + 1'b1;
            end
        end
        if (cmd.take_goto) begin
            dead_reg <= 1'b0;
        end else if (cmd.take_dead) begin
            dead_reg <= 1'b1;
        end
    end

    // Current automaton state; the root after reset.
    always_comb begin
        cur_next = cur_reg;
        if (cmd.take_goto) begin
            cur_next = goto_q[STATE_W-1:0];
        end else if (cmd.take_dead) begin
            cur_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg <= '0;
        end else begin
            cur_reg <= cur_next;
        end
    end

    // Lowest pattern index in the bitmap of the new state.
    always_comb begin
        bits     = out_q & PAT_MASK;
        bits_any = |bits;
        bits_low = '0;
        for (int j = PAT_W - 1; j >= 0; j--) begin
            if (bits[j]) begin
                bits_low = IDX_W'(j);
            end
        end
    end

    // Result word register and its valid flag.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_match || cmd.load_zero) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_match) begin
            found_reg    <= bits_any;
            index_reg    <= bits_low;
            dead_out_reg <= dead_reg;
        end else if (cmd.load_zero) begin
            found_reg    <= 1'b0;
            index_reg    <= '0;
            dead_out_reg <= 1'b0;
        end
    end

    assign stat.goto_def  = !goto_q[TGT_W-1];
    assign stat.fail_left = (fcnt_reg < FCNT_W'(MAX_FAIL));
    assign stat.out_free  = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_match_hit   = found_reg;
    assign m_match_index = index_reg;
    assign m_dead_end    = dead_out_reg;

endmodule
`default_nettype wire

// ===== src/acm_checker.sv =====
// Port-level checks for aho_corasick_match_step, attached by bind.
// Depends only on the top level's ports.
`default_nettype none
module acm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_match_hit,
    input wire logic [3:0]  m_match_index,
    input wire logic        m_dead_end
);

    // A stalled result word stays valid.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable({m_match_hit, m_match_index, m_dead_end}))
        else $error("result payload changed while stalled");

    // Without a match the index reads as zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_match_hit |-> m_match_index == 4'd0)
        else $error("match index set without a match");

    // Only one word is in flight: input closes right after an accept.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word taken while one is in flight");

    // Reset empties the result register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind aho_corasick_match_step acm_checker u_acm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_match_hit   (m_match_hit),
    .m_match_index (m_match_index),
    .m_dead_end    (m_dead_end)
);
`default_nettype wire
